@@ sv/kte_pkg.sv @@
// Shared types and constants for the keyframe tangent estimator.
// No dependencies; imported by kte_slope and keyframe_tangent_estimator.
package kte_pkg;

    localparam int KEY_W = 32;
    localparam int TOL_W = 16;

    localparam logic [KEY_W-1:0] SLOPE_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic [KEY_W-1:0] SLOPE_MIN = {1'b1, {(KEY_W-1){1'b0}}};

    // One stored key: unsigned time, signed value (both fixed point).
    typedef struct packed {
        logic [KEY_W-1:0] key_time;
        logic [KEY_W-1:0] key_value;
    } t_key;

    // One tangent: slope and the infinite flag.
    typedef struct packed {
        logic [KEY_W-1:0] slope;
        logic             inf;
    } t_slope;

endpackage

@@ sv/kte_slope.sv @@
// Bit-serial slope unit: (dv << FRAC_BITS) / dt, truncated and saturated; infinite flag if |dt| <= tol.
// Depends on kte_pkg for t_key, t_slope and the saturation constants.
module kte_slope
    import kte_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_key             i_key_a,
    input  t_key             i_key_b,
    input  logic [TOL_W-1:0] i_tol,
    output logic             o_done,
    output t_slope           o_res
);

    localparam int NW  = KEY_W + 1 + FRAC_BITS;   // numerator magnitude width
    localparam int HW  = NW - KEY_W;              // bits above the quotient window
    localparam int CNT_W = $clog2(KEY_W);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_ABS  = 3'd1;
    localparam logic [2:0] P_CHK  = 3'd2;
    localparam logic [2:0] P_RUN  = 3'd3;
    localparam logic [2:0] P_FIX  = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [KEY_W:0]   r_dt, n_dt;
    logic [KEY_W:0]   r_dv, n_dv;
    logic [KEY_W-1:0] r_dmag, n_dmag;
    logic [KEY_W:0]   r_nmag, n_nmag;
    logic             r_neg, n_neg;
    logic [KEY_W-1:0] r_rem, n_rem;
    logic [KEY_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    t_slope           r_res, n_res;

    logic [NW-1:0]    numer;
    logic [HW-1:0]    numer_hi;
    logic [KEY_W:0]   trial;
    logic [KEY_W:0]   diff;

    always_comb begin
        n_phase = r_phase;
        n_dt    = r_dt;
        n_dv    = r_dv;
        n_dmag  = r_dmag;
        n_nmag  = r_nmag;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_res   = r_res;

        numer    = NW'(r_nmag) << FRAC_BITS;
        numer_hi = numer[NW-1:KEY_W];
        trial    = {r_rem, r_quo[KEY_W-1]};
        diff     = trial - {1'b0, r_dmag};

        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_dt = {1'b0, i_key_b.key_time} - {1'b0, i_key_a.key_time};
                    n_dv = {i_key_b.key_value[KEY_W-1], i_key_b.key_value}
                         - {i_key_a.key_value[KEY_W-1], i_key_a.key_value};
                    n_phase = P_ABS;
                end
            end
            P_ABS: begin
                // take magnitudes; the quotient sign is kept aside
                n_dmag  = r_dt[KEY_W] ? KEY_W'(~r_dt + 1'b1) : r_dt[KEY_W-1:0];
                n_nmag  = r_dv[KEY_W] ? (~r_dv + 1'b1) : r_dv;
                n_neg   = r_dt[KEY_W] ^ r_dv[KEY_W];
                n_phase = P_CHK;
            end
            P_CHK: begin
                if (r_dmag <= KEY_W'(i_tol)) begin
                    n_res   = '{slope: '0, inf: 1'b1};
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else if (KEY_W'(numer_hi) >= r_dmag) begin
                    // quotient reaches 2^32: saturate without dividing
                    n_res   = '{slope: (r_neg ? SLOPE_MIN : SLOPE_MAX), inf: 1'b0};
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end else begin
                    n_rem   = KEY_W'(numer_hi);
                    n_quo   = numer[KEY_W-1:0];
                    n_cnt   = '0;
                    n_phase = P_RUN;
                end
            end
            P_RUN: begin
                // one quotient bit per cycle, shifted in as the dividend shifts out
                if (!diff[KEY_W]) begin
                    n_rem = diff[KEY_W-1:0];
                    n_quo = {r_quo[KEY_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[KEY_W-1:0];
                    n_quo = {r_quo[KEY_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    n_phase = P_FIX;
                end
            end
            P_FIX: begin
                if (!r_neg) begin
                    n_res.slope = r_quo[KEY_W-1] ? SLOPE_MAX : r_quo;
                end else if (r_quo[KEY_W-1] && |r_quo[KEY_W-2:0]) begin
                    n_res.slope = SLOPE_MIN;
                end else begin
                    n_res.slope = ~r_quo + 1'b1;
                end
                n_res.inf = 1'b0;
                n_done    = 1'b1;
                n_phase   = P_IDLE;
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_dt   <= n_dt;
        r_dv   <= n_dv;
        r_dmag <= n_dmag;
        r_nmag <= n_nmag;
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ sv/keyframe_tangent_estimator.sv @@
// Keyframe tangent estimator top level: key store, sequencer, output register.
// Depends on kte_pkg and kte_slope (bit-serial slope divider).
// A held key leaves after its successor is accepted and its slope is done, or after
// both the central and the end slope are done when a curve's last key needs both.
// Keys are taken one at a time: the input is held while the 32-step shift-subtract
// loop in kte_slope runs and the key is emitted, longer for a curve's last key; a slope
// inside the tolerance or one that saturates ends early, and the first key of a curve
// is only stored.
// Reset (synchronous, active low) clears the sequencer, the held-key state and the
// output valid, and sets the time tolerance to 1; stored keys need no clearing.
module keyframe_tangent_estimator
    import kte_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write: time_tolerance
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TOL_W-1:0]     i_cfg_data,
    // key request in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*KEY_W-1:0]   s_axis_tdata,  // key_time, key_value
    input  logic                 s_axis_tlast,  // last_key
    // key with tangents out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [4*KEY_W-1:0]   m_axis_tdata,  // out_time, out_value, in_slope, out_slope
    output logic [1:0]           m_axis_tuser,  // in_infinite, out_infinite
    output logic                 m_axis_tlast   // curve_end
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;  // wait for a key
    localparam logic [2:0] S_LAUNCH = 3'd1;  // start one slope
    localparam logic [2:0] S_WAIT   = 3'd2;  // wait for the slope unit
    localparam logic [2:0] S_PUT1   = 3'd3;  // emit the held key
    localparam logic [2:0] S_PUT2   = 3'd4;  // emit the curve's last key

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_FIRST = 2'd1;
    localparam logic [1:0] HELD_INNER = 2'd2;

    logic [2:0]       r_state, n_state;
    logic [1:0]       r_held, n_held;
    logic [TOL_W-1:0] r_tol, n_tol;
    t_key             r_older, n_older;
    t_key             r_recent, n_recent;
    t_key             r_new, n_new;
    logic             r_last, n_last;
    logic             r_calc_a, n_calc_a;    // current slope is older -> new
    t_slope           r_sa, n_sa;            // central slope
    t_slope           r_sb, n_sb;            // slope recent -> new

    logic               r_ovalid, n_ovalid;
    logic [4*KEY_W-1:0] r_odata, n_odata;
    logic [1:0]         r_ouser, n_ouser;
    logic               r_olast, n_olast;

    logic   in_req;
    logic   out_free;
    logic   slope_start;
    logic   slope_done;
    t_slope slope_res;
    t_key   slope_base;
    t_key   in_key;
    t_slope in_tan;
    t_slope out_tan;

    assign in_key   = '{key_time: s_axis_tdata[KEY_W-1:0],
                        key_value: s_axis_tdata[2*KEY_W-1:KEY_W]};
    assign in_req   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign slope_start   = (r_state == S_LAUNCH);
    assign slope_base    = r_calc_a ? r_older : r_recent;

    kte_slope #(
        .FRAC_BITS (FRAC_BITS)
    ) u_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (slope_start),
        .i_key_a (slope_base),
        .i_key_b (r_new),
        .i_tol   (r_tol),
        .o_done  (slope_done),
        .o_res   (slope_res)
    );

    // tangents of the held key: first key gets a zero in tangent
    always_comb begin
        if (r_held == HELD_FIRST) begin
            in_tan  = '0;
            out_tan = r_sb;
        end else begin
            in_tan  = r_sa;
            out_tan = r_sa;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_tol    = r_tol;
        n_older  = r_older;
        n_recent = r_recent;
        n_new    = r_new;
        n_last   = r_last;
        n_calc_a = r_calc_a;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;

        if (i_cfg_valid) begin
            n_tol = i_cfg_data;
        end

        // drop the output once taken; a load below overrides this
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    n_new  = in_key;
                    n_last = s_axis_tlast;
                    if (r_held == HELD_NONE) begin
                        if (s_axis_tlast) begin
                            // lone key: both tangents zero
                            n_sb    = '0;
                            n_state = S_PUT2;
                        end else begin
                            n_recent = in_key;
                            n_held   = HELD_FIRST;
                        end
                    end else begin
                        n_calc_a = (r_held == HELD_INNER);
                        n_state  = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (slope_done) begin
                    if (r_calc_a) begin
                        n_sa = slope_res;
                        if (r_last) begin
                            // the last key still needs its own in tangent
                            n_calc_a = 1'b0;
                            n_state  = S_LAUNCH;
                        end else begin
                            n_state = S_PUT1;
                        end
                    end else begin
                        n_sb    = slope_res;
                        n_state = S_PUT1;
                    end
                end
            end
            S_PUT1: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {out_tan.slope, in_tan.slope,
                                r_recent.key_value, r_recent.key_time};
                    n_ouser  = {out_tan.inf, in_tan.inf};
                    n_olast  = 1'b0;
                    if (r_last) begin
                        n_state = S_PUT2;
                    end else begin
                        // advance the key window
                        n_older  = r_recent;
                        n_recent = r_new;
                        n_held   = HELD_INNER;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_PUT2: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {{KEY_W{1'b0}}, r_sb.slope,
                                r_new.key_value, r_new.key_time};
                    n_ouser  = {1'b0, r_sb.inf};
                    n_olast  = 1'b1;
                    n_held   = HELD_NONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= HELD_NONE;
            r_tol    <= TOL_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_tol    <= n_tol;
            r_ovalid <= n_ovalid;
        end
        r_older  <= n_older;
        r_recent <= n_recent;
        r_new    <= n_new;
        r_last   <= n_last;
        r_calc_a <= n_calc_a;
        r_sa     <= n_sa;
        r_sb     <= n_sb;
        r_odata  <= n_odata;
        r_ouser  <= n_ouser;
        r_olast  <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule
